FILE: hdl/mfrt_pkg.sv
// Shared types, codes and constants of the flow rule table.
package mfrt_pkg;
	localparam int TableSlots = 32;
	localparam int SlotW = $clog2(TableSlots);
	localparam int CountW = $clog2(TableSlots + 1);

	// For any 32-bit n, bits 63:35 of n*DivTenRecip give n/10 rounded down.
	localparam logic [31:0] DivTenRecip = 32'hCCCC_CCCD;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SET = 3'd1,
		OP_DEL = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_AGG = 3'd4,
		OP_QUERY = 3'd5,
		OP_CLEAR = 3'd6,
		OP_NONE = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EXISTS = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		CFG_DEFAULT_ALGO = 1'b0,
		CFG_MIN_ACKS = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_CALC,
		S_AVG,
		S_WRITE,
		S_RENUM,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_step;
		logic read_hit;
		logic calc;
		logic avg_step;
		logic write;
		logic renum_step;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic scan_last;
		logic avg_last;
		logic renum_last;
		op_t op;
	} dp_stat_t;
endpackage

FILE: hdl/mfrt_ctrl.sv
// Controller state machine that sequences one table operation.
module mfrt_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input mfrt_pkg::dp_stat_t stat,
	output mfrt_pkg::dp_cmd_t cmd
);
	import mfrt_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_last) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.read_hit = 1'b1;
				state_d = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				if (stat.op == OP_AGG) begin
					state_d = S_AVG;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_AVG: begin
				cmd.avg_step = 1'b1;
				if (stat.avg_last) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				cmd.write = 1'b1;
				if (stat.op == OP_DEL || stat.op == OP_CLEAR) begin
					state_d = S_RENUM;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RENUM: begin
				cmd.renum_step = 1'b1;
				if (stat.renum_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

FILE: hdl/mfrt_dp.sv
// Datapath: rule memories, slot scan, statistics update and result register.
module mfrt_dp (
	input logic clk,
	input logic arst_n,
	input mfrt_pkg::dp_cmd_t cmd,
	output mfrt_pkg::dp_stat_t stat,
	input logic [2:0] op,
	input logic [31:0] local_addr,
	input logic [31:0] local_mask,
	input logic [31:0] remote_addr,
	input logic [31:0] remote_mask,
	input logic [15:0] rule_priority,
	input logic [3:0] algo_index,
	input logic [31:0] sample_acks,
	input logic [31:0] sample_losses,
	input logic [31:0] sample_rtt,
	input logic [3:0] default_algo,
	input logic [31:0] min_acks_for_update,
	output logic done,
	output logic [1:0] status,
	output logic [3:0] result_algo,
	output logic [31:0] hit_local_addr,
	output logic [31:0] hit_remote_addr,
	output logic [15:0] hit_priority,
	output logic [31:0] avg_acks,
	output logic [31:0] avg_losses,
	output logic [31:0] avg_rtt
);
	import mfrt_pkg::*;

	// Key memory (read during the scan) and content memory.
	logic [31:0] m_la [TableSlots];
	logic [31:0] m_ra [TableSlots];
	logic [15:0] m_pr [TableSlots];
	logic [SlotW-1:0] m_rank [TableSlots];
	logic [3:0] m_algo [TableSlots];
	logic [31:0] m_acks [TableSlots];
	logic [31:0] m_loss [TableSlots];
	logic [31:0] m_rtt [TableSlots];
	logic [TableSlots-1:0] valid_q;

	op_t op_q;
	logic [31:0] la_q, lm_q, ra_q, rm_q, sa_q, sl_q, sr_q;
	logic [15:0] pr_q;
	logic [3:0] algo_q;
	logic [SlotW-1:0] idx_q;
	logic [CountW-1:0] count_q;
	logic found_q, free_found_q;
	logic [SlotW-1:0] hit_q, free_q, hit_rank_q, best_rank_q;

	logic [31:0] k_la, k_ra;
	logic [15:0] k_pr;
	logic [SlotW-1:0] k_rank;
	logic [3:0] c_algo;
	logic [31:0] c_acks, c_loss, c_rtt;
	logic [3:0] n_algo;
	logic [31:0] n_acks, n_loss, n_rtt;
	logic [1:0] st_q;
	logic report_q, use_default_q;
	logic [SlotW-1:0] rep_q;

	logic cmp_valid_s1;
	logic [SlotW-1:0] cmp_idx_s1;
	logic match;
	logic [SlotW-1:0] tgt;

	// Averaging unit: each statistic takes a reciprocal multiply step, then a combine step.
	logic blend_q;
	logic [2:0] avg_cnt_q;
	logic [28:0] qx_q, qs_q;
	logic [31:0] avg_x, avg_s;
	logic [63:0] prod_x, prod_s;
	logic [31:0] qx10;
	logic [33:0] avg_sum;
	logic [31:0] avg_new;

	assign stat.op = op_q;
	assign stat.scan_last = cmp_valid_s1 && (cmp_idx_s1 == SlotW'(TableSlots - 1));
	assign stat.avg_last = (avg_cnt_q == 3'd5);
	assign stat.renum_last = (idx_q == SlotW'(TableSlots - 1));

	// Key read for the scan, registered.
	always_ff @(posedge clk) begin
		k_la <= m_la[idx_q];
		k_ra <= m_ra[idx_q];
		k_pr <= m_pr[idx_q];
		k_rank <= m_rank[idx_q];
	end

	assign match = valid_q[cmp_idx_s1] && cmp_valid_s1
		&& ((k_la & lm_q) == (la_q & lm_q)) && ((k_ra & rm_q) == (ra_q & rm_q))
		&& (k_pr == pr_q);
	assign tgt = (op_q == OP_ADD && !found_q) ? free_q : hit_q;

	always_comb begin
		unique case (avg_cnt_q[2:1])
			2'd0: begin
				avg_x = c_acks;
				avg_s = sa_q;
			end
			2'd1: begin
				avg_x = c_loss;
				avg_s = sl_q;
			end
			default: begin
				avg_x = c_rtt;
				avg_s = sr_q;
			end
		endcase
	end

	assign prod_x = {32'd0, avg_x} * {32'd0, DivTenRecip};
	assign prod_s = {32'd0, avg_s} * {32'd0, DivTenRecip};
	// x*9/10 rounded down is x minus x/10 rounded up.
	assign qx10 = {qx_q, 3'd0} + {2'd0, qx_q, 1'd0};
	assign avg_sum = {2'd0, avg_x} - {5'd0, qx_q} - {33'd0, (avg_x != qx10)}
		+ {5'd0, qs_q};
	assign avg_new = (avg_sum > 34'h0FFFFFFFF) ? 32'hFFFFFFFF : avg_sum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cmp_valid_s1 <= 1'b0;
			done <= 1'b0;
			idx_q <= '0;
		end else begin
			done <= cmd.finish;
			cmp_valid_s1 <= 1'b0;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.scan_step) begin
				if (idx_q != SlotW'(TableSlots - 1)) begin
					idx_q <= idx_q + 1'b1;
				end
				cmp_valid_s1 <= (cmp_idx_s1 != SlotW'(TableSlots - 1)) || !cmp_valid_s1;
			end else if (cmd.write) begin
				idx_q <= '0;
			end else if (cmd.renum_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.write) begin
				unique case (op_q)
					OP_ADD: if (!found_q && free_found_q) valid_q[free_q] <= 1'b1;
					OP_DEL: if (found_q) valid_q[hit_q] <= 1'b0;
					OP_CLEAR: valid_q <= '0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= op_t'(op);
			la_q <= local_addr;
			ra_q <= remote_addr;
			lm_q <= local_mask;
			rm_q <= remote_mask;
			pr_q <= rule_priority;
			if (op_t'(op) == OP_LOOKUP || op_t'(op) == OP_AGG) begin
				lm_q <= '1;
				rm_q <= '1;
				pr_q <= '0;
			end
			algo_q <= algo_index;
			sa_q <= sample_acks;
			sl_q <= sample_losses;
			sr_q <= sample_rtt;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			count_q <= '0;
			cmp_idx_s1 <= '0;
			best_rank_q <= '0;
		end
		if (cmd.scan_step) begin
			if (cmp_valid_s1) begin
				if (cmp_idx_s1 != SlotW'(TableSlots - 1)) begin
					cmp_idx_s1 <= cmp_idx_s1 + 1'b1;
				end
				if (valid_q[cmp_idx_s1]) begin
					count_q <= count_q + 1'b1;
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_q <= cmp_idx_s1;
				end
				if (match && (!found_q || k_rank > best_rank_q)) begin
					found_q <= 1'b1;
					hit_q <= cmp_idx_s1;
					best_rank_q <= k_rank;
				end
			end
		end
		// Content read of the chosen slot.
		if (cmd.read_hit) begin
			c_algo <= m_algo[tgt];
			c_acks <= m_acks[tgt];
			c_loss <= m_loss[tgt];
			c_rtt <= m_rtt[tgt];
			hit_rank_q <= best_rank_q;
		end
		if (cmd.calc) begin
			n_algo <= c_algo;
			n_acks <= c_acks;
			n_loss <= c_loss;
			n_rtt <= c_rtt;
			st_q <= ST_OK;
			report_q <= found_q;
			use_default_q <= 1'b0;
			rep_q <= hit_q;
			blend_q <= 1'b0;
			avg_cnt_q <= '0;
			unique case (op_q)
				OP_ADD: begin
					if (found_q) begin
						st_q <= ST_EXISTS;
					end else if (!free_found_q) begin
						st_q <= ST_FULL;
					end else begin
						report_q <= 1'b1;
						rep_q <= free_q;
						n_algo <= algo_q;
						n_acks <= '0;
						n_loss <= '0;
						n_rtt <= '0;
					end
				end
				OP_SET: begin
					if (!found_q) st_q <= ST_NOT_FOUND;
					n_algo <= algo_q;
					n_acks <= '0;
					n_loss <= '0;
					n_rtt <= '0;
				end
				OP_AGG: begin
					if (!found_q) begin
						st_q <= ST_NOT_FOUND;
					end else if (c_acks == '0 && c_loss == '0 && c_rtt == '0) begin
						n_acks <= sa_q;
						n_loss <= sl_q;
						n_rtt <= sr_q;
					end else if (sa_q > min_acks_for_update) begin
						blend_q <= 1'b1;
					end
				end
				OP_LOOKUP: begin
					if (!found_q) begin
						st_q <= ST_NOT_FOUND;
						use_default_q <= 1'b1;
					end
				end
				OP_DEL, OP_QUERY: if (!found_q) st_q <= ST_NOT_FOUND;
				OP_CLEAR, OP_NONE: report_q <= 1'b0;
				default: ;
			endcase
		end
		if (cmd.avg_step) begin
			avg_cnt_q <= avg_cnt_q + 1'b1;
			if (!avg_cnt_q[0]) begin
				qx_q <= prod_x[63:35];
				qs_q <= prod_s[63:35];
			end else if (blend_q) begin
				unique case (avg_cnt_q[2:1])
					2'd0: n_acks <= avg_new;
					2'd1: n_loss <= avg_new;
					default: n_rtt <= avg_new;
				endcase
			end
		end
		if (cmd.write && report_q) begin
			m_algo[rep_q] <= n_algo;
			m_acks[rep_q] <= n_acks;
			m_loss[rep_q] <= n_loss;
			m_rtt[rep_q] <= n_rtt;
			if (op_q == OP_ADD && !found_q) begin
				m_la[rep_q] <= la_q;
				m_ra[rep_q] <= ra_q;
				m_pr[rep_q] <= pr_q;
				m_rank[rep_q] <= count_q[SlotW-1:0];
			end
		end
		// Ranks above a deleted rule close the gap, one slot a cycle.
		if (cmd.renum_step && op_q == OP_DEL && found_q) begin
			if (valid_q[idx_q] && m_rank[idx_q] > hit_rank_q) begin
				m_rank[idx_q] <= m_rank[idx_q] - 1'b1;
			end
		end
		if (cmd.finish) begin
			status <= st_q;
			result_algo <= report_q ? n_algo : (use_default_q ? default_algo : '0);
			hit_local_addr <= report_q ? m_la[rep_q] : '0;
			hit_remote_addr <= report_q ? m_ra[rep_q] : '0;
			hit_priority <= report_q ? m_pr[rep_q] : '0;
			avg_acks <= report_q ? n_acks : '0;
			avg_losses <= report_q ? n_loss : '0;
			avg_rtt <= report_q ? n_rtt : '0;
		end
	end
endmodule

FILE: hdl/masked_flow_rule_table_with_ewma_stats_core.sv
// Flow rule table: 32 masked rules, newest match wins, averaged statistics per rule.
// One operation runs from start through the scan to the result strobe; aggregate adds
// the averaging steps, and delete and clear add a renumbering pass over the slots.
// The scan reads one slot of the key memory per cycle.
// Reset empties the table and loads default_algo 0 and min_acks_for_update 50.
module masked_flow_rule_table_with_ewma_stats_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input logic [2:0] op,
	input logic [31:0] local_addr,
	input logic [31:0] local_mask,
	input logic [31:0] remote_addr,
	input logic [31:0] remote_mask,
	input logic [15:0] rule_priority,
	input logic [3:0] algo_index,
	input logic [31:0] sample_acks,
	input logic [31:0] sample_losses,
	input logic [31:0] sample_rtt,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [0:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic [1:0] status,
	output logic [3:0] result_algo,
	output logic [31:0] hit_local_addr,
	output logic [31:0] hit_remote_addr,
	output logic [15:0] hit_priority,
	output logic [31:0] avg_acks,
	output logic [31:0] avg_losses,
	output logic [31:0] avg_rtt
);
	import mfrt_pkg::*;

	dp_cmd_t cmd;
	dp_stat_t stat;
	logic [3:0] default_algo_q;
	logic [31:0] min_acks_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_algo_q <= 4'd0;
			min_acks_q <= 32'd50;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_DEFAULT_ALGO: default_algo_q <= cfg_data[3:0];
				CFG_MIN_ACKS: min_acks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mfrt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	mfrt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.op(op), .local_addr(local_addr), .local_mask(local_mask),
		.remote_addr(remote_addr), .remote_mask(remote_mask),
		.rule_priority(rule_priority), .algo_index(algo_index),
		.sample_acks(sample_acks), .sample_losses(sample_losses),
		.sample_rtt(sample_rtt), .default_algo(default_algo_q),
		.min_acks_for_update(min_acks_q), .done(done), .status(status),
		.result_algo(result_algo), .hit_local_addr(hit_local_addr),
		.hit_remote_addr(hit_remote_addr), .hit_priority(hit_priority),
		.avg_acks(avg_acks), .avg_losses(avg_losses), .avg_rtt(avg_rtt)
	);

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_finish_then_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> done) else $error("missing result strobe");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("operation not started");
endmodule

FILE: test/masked_flow_rule_table_with_ewma_stats_core_tb.sv
// Testbench for the flow rule table: random and directed operations checked against a predictor.
module masked_flow_rule_table_with_ewma_stats_core_tb;
	import mfrt_pkg::*;

	localparam int CycleLimit = 2000000;
	localparam int RandomOps = 1130;

	typedef struct {
		status_t status;
		logic [3:0] algo;
		logic [31:0] local_addr;
		logic [31:0] remote_addr;
		logic [15:0] prio;
		logic [31:0] acks;
		logic [31:0] losses;
		logic [31:0] rtt;
	} rule_word_t;

	// Tracks the rule table and queues the word each operation should return.
	class rule_table_scoreboard;
		bit valid_q[TableSlots];
		int unsigned recency[TableSlots];
		logic [31:0] t_local[TableSlots];
		logic [31:0] t_remote[TableSlots];
		logic [15:0] t_prio[TableSlots];
		logic [3:0] t_algo[TableSlots];
		logic [31:0] t_acks[TableSlots];
		logic [31:0] t_losses[TableSlots];
		logic [31:0] t_rtt[TableSlots];
		logic [3:0] default_algo;
		logic [31:0] min_acks;
		rule_word_t pending_words[$];
		int errors;

		function new();
			default_algo = 4'd0;
			min_acks = 32'd50;
			errors = 0;
			foreach (valid_q[i]) valid_q[i] = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [31:0] data);
			if (idx == CFG_DEFAULT_ALGO) default_algo = data[3:0];
			else min_acks = data;
		endfunction

		function int find_rule(logic [31:0] la, logic [31:0] lm, logic [31:0] ra,
				logic [31:0] rm, logic [15:0] pr);
			int best;
			best = -1;
			for (int i = 0; i < TableSlots; i++) begin
				if (valid_q[i] && (t_local[i] & lm) == (la & lm)
						&& (t_remote[i] & rm) == (ra & rm) && t_prio[i] == pr
						&& (best < 0 || recency[i] > recency[best]))
					best = i;
			end
			return best;
		endfunction

		function logic [31:0] ewma(logic [31:0] x, logic [31:0] s);
			logic [63:0] v;
			v = (64'(x) * 64'd9) / 64'd10 + 64'(s) / 64'd10;
			return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function void fill_word(int s, ref rule_word_t w);
			w.algo = t_algo[s];
			w.local_addr = t_local[s];
			w.remote_addr = t_remote[s];
			w.prio = t_prio[s];
			w.acks = t_acks[s];
			w.losses = t_losses[s];
			w.rtt = t_rtt[s];
		endfunction

		function void note_op(op_t code, logic [31:0] la, logic [31:0] lm, logic [31:0] ra,
				logic [31:0] rm, logic [15:0] pr, logic [3:0] algo, logic [31:0] sa,
				logic [31:0] sl, logic [31:0] sr);
			rule_word_t w;
			int s;
			int unsigned count;
			w = '{ST_OK, 0, 0, 0, 0, 0, 0, 0};
			case (code)
				OP_ADD: begin
					s = find_rule(la, lm, ra, rm, pr);
					if (s >= 0) begin
						w.status = ST_EXISTS;
						fill_word(s, w);
					end else begin
						count = 0;
						for (int i = 0; i < TableSlots; i++) begin
							if (valid_q[i]) count++;
							else if (s < 0) s = i;
						end
						if (s < 0) begin
							w.status = ST_FULL;
						end else begin
							valid_q[s] = 1;
							recency[s] = count;
							t_local[s] = la;
							t_remote[s] = ra;
							t_prio[s] = pr;
							t_algo[s] = algo;
							t_acks[s] = 0;
							t_losses[s] = 0;
							t_rtt[s] = 0;
							fill_word(s, w);
						end
					end
				end
				OP_SET: begin
					s = find_rule(la, lm, ra, rm, pr);
					if (s < 0) begin
						w.status = ST_NOT_FOUND;
					end else begin
						t_algo[s] = algo;
						t_acks[s] = 0;
						t_losses[s] = 0;
						t_rtt[s] = 0;
						fill_word(s, w);
					end
				end
				OP_DEL: begin
					s = find_rule(la, lm, ra, rm, pr);
					if (s < 0) begin
						w.status = ST_NOT_FOUND;
					end else begin
						fill_word(s, w);
						valid_q[s] = 0;
						for (int i = 0; i < TableSlots; i++)
							if (valid_q[i] && recency[i] > recency[s]) recency[i]--;
					end
				end
				OP_LOOKUP: begin
					s = find_rule(la, '1, ra, '1, 16'd0);
					if (s < 0) begin
						w.status = ST_NOT_FOUND;
						w.algo = default_algo;
					end else begin
						fill_word(s, w);
					end
				end
				OP_AGG: begin
					s = find_rule(la, '1, ra, '1, 16'd0);
					if (s < 0) begin
						w.status = ST_NOT_FOUND;
					end else begin
						if (t_acks[s] == 0 && t_losses[s] == 0 && t_rtt[s] == 0) begin
							t_acks[s] = sa;
							t_losses[s] = sl;
							t_rtt[s] = sr;
						end else if (sa > min_acks) begin
							t_acks[s] = ewma(t_acks[s], sa);
							t_losses[s] = ewma(t_losses[s], sl);
							t_rtt[s] = ewma(t_rtt[s], sr);
						end
						fill_word(s, w);
					end
				end
				OP_QUERY: begin
					s = find_rule(la, lm, ra, rm, pr);
					if (s < 0) w.status = ST_NOT_FOUND;
					else fill_word(s, w);
				end
				OP_CLEAR: begin
					foreach (valid_q[i]) valid_q[i] = 0;
				end
				default: ;
			endcase
			pending_words.push_back(w);
		endfunction

		function void check_result(rule_word_t got);
			rule_word_t want;
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10) $display("ERROR: result word with nothing expected");
				return;
			end
			want = pending_words.pop_front();
			if (got.status !== want.status || got.algo !== want.algo
					|| got.local_addr !== want.local_addr
					|| got.remote_addr !== want.remote_addr || got.prio !== want.prio
					|| got.acks !== want.acks || got.losses !== want.losses
					|| got.rtt !== want.rtt) begin
				errors++;
				if (errors <= 10) begin
					$display("ERROR: expected st=%0d algo=%h la=%h ra=%h pr=%h a=%h l=%h r=%h",
						want.status, want.algo, want.local_addr, want.remote_addr, want.prio,
						want.acks, want.losses, want.rtt);
					$display("       got st=%0d algo=%h la=%h ra=%h pr=%h a=%h l=%h r=%h",
						got.status, got.algo, got.local_addr, got.remote_addr, got.prio,
						got.acks, got.losses, got.rtt);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	logic [2:0] op;
	logic [31:0] local_addr;
	logic [31:0] local_mask;
	logic [31:0] remote_addr;
	logic [31:0] remote_mask;
	logic [15:0] rule_priority;
	logic [3:0] algo_index;
	logic [31:0] sample_acks;
	logic [31:0] sample_losses;
	logic [31:0] sample_rtt;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;
	logic [1:0] status;
	logic [3:0] result_algo;
	logic [31:0] hit_local_addr;
	logic [31:0] hit_remote_addr;
	logic [15:0] hit_priority;
	logic [31:0] avg_acks;
	logic [31:0] avg_losses;
	logic [31:0] avg_rtt;

	rule_table_scoreboard sb = new();
	int cycles = 0;
	logic [31:0] addr_pool[8];

	masked_flow_rule_table_with_ewma_stats_core u_top (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		rule_word_t got;
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
		if (arst_n && done) begin
			got = '{status_t'(status), result_algo, hit_local_addr, hit_remote_addr,
				hit_priority, avg_acks, avg_losses, avg_rtt};
			sb.check_result(got);
		end
	end

	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_op(op_t code, logic [31:0] la, logic [31:0] lm, logic [31:0] ra,
			logic [31:0] rm, logic [15:0] pr, logic [3:0] algo, logic [31:0] sa,
			logic [31:0] sl, logic [31:0] sr);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op <= code;
		local_addr <= la;
		local_mask <= lm;
		remote_addr <= ra;
		remote_mask <= rm;
		rule_priority <= pr;
		algo_index <= algo;
		sample_acks <= sa;
		sample_losses <= sl;
		sample_rtt <= sr;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_op(code, la, lm, ra, rm, pr, algo, sa, sl, sr);
	endtask

	// Registers change only once the table has answered every word.
	task automatic write_reg(cfg_index_t idx, logic [31:0] data);
		start <= 1'b0;
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	function logic [31:0] pick_addr();
		return ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, 7)];
	endfunction

	function logic [31:0] pick_mask();
		case ($urandom_range(0, 5))
			0, 1, 2: return 32'hFFFF_FFFF;
			3: return 32'h0;
			4: return 32'hFFFF_FF00;
			default: return $urandom();
		endcase
	endfunction

	function logic [31:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 100);
			default: return $urandom();
		endcase
	endfunction

	task automatic random_op(int add_weight);
		op_t code;
		logic [15:0] pr;
		int r;
		r = $urandom_range(0, 99);
		if (r < add_weight) code = OP_ADD;
		else if (r > 98) code = ($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_NONE;
		else code = op_t'($urandom_range(1, 5));
		case ($urandom_range(0, 3))
			0, 1: pr = 16'd0;
			2: pr = 16'd1;
			default: pr = 16'($urandom());
		endcase
		send_op(code, pick_addr(), pick_mask(), pick_addr(), pick_mask(), pr,
			4'($urandom()), pick_sample(), pick_sample(), pick_sample());
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_NONE;
		local_addr = '0;
		local_mask = '0;
		remote_addr = '0;
		remote_mask = '0;
		rule_priority = '0;
		algo_index = '0;
		sample_acks = '0;
		sample_losses = '0;
		sample_rtt = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_DEFAULT_ALGO;
		cfg_data = '0;
		foreach (addr_pool[i]) addr_pool[i] = $urandom();
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hFFFF_FFFF;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: misses on an empty table, then hits, duplicates and the averaging paths.
		send_op(OP_LOOKUP, 32'h0, '1, 32'h0, '1, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_QUERY, 32'h1, '1, 32'h2, '1, 16'd3, 4'h0, 0, 0, 0);
		send_op(OP_ADD, 32'h0, '1, 32'hFFFF_FFFF, '1, 16'd0, 4'hF, 0, 0, 0);
		send_op(OP_ADD, 32'hFFFF_FFFF, '1, 32'h0, '1, 16'hFFFF, 4'h0, 0, 0, 0);
		send_op(OP_ADD, 32'h0, '1, 32'hFFFF_FFFF, '1, 16'd0, 4'h3, 0, 0, 0);
		send_op(OP_ADD, 32'h0, '0, 32'h0, '0, 16'd0, 4'h5, 0, 0, 0);
		send_op(OP_AGG, 32'h0, '0, 32'hFFFF_FFFF, '0, 16'd0, 4'h0, '1, '1, '1);
		send_op(OP_AGG, 32'h0, '0, 32'hFFFF_FFFF, '0, 16'd0, 4'h0, '1, '1, '1);
		send_op(OP_AGG, 32'h0, '0, 32'hFFFF_FFFF, '0, 16'd0, 4'h0, 32'd50, 7, 7);
		send_op(OP_AGG, 32'h0, '0, 32'hFFFF_FFFF, '0, 16'd0, 4'h0, 32'd51, 0, 0);
		send_op(OP_AGG, 32'h5, '0, 32'h5, '0, 16'd0, 4'h0, 32'd99, 1, 1);
		send_op(OP_SET, 32'h0, '1, 32'hFFFF_FFFF, '1, 16'd0, 4'hA, 0, 0, 0);
		send_op(OP_SET, 32'h7, '1, 32'h7, '1, 16'd0, 4'hA, 0, 0, 0);
		send_op(OP_QUERY, 32'h0, '0, 32'h0, '0, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_QUERY, 32'h0, '0, 32'h0, '0, 16'hFFFF, 4'h0, 0, 0, 0);
		send_op(OP_DEL, 32'h0, '0, 32'h0, '0, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_DEL, 32'h0, '0, 32'h0, '0, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_DEL, 32'h0, '0, 32'h0, '0, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_LOOKUP, 32'hFFFF_FFFF, '1, 32'h0, '1, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_NONE, '1, '1, '1, '1, '1, '1, '1, '1, '1);
		send_op(OP_CLEAR, 32'h0, '0, 32'h0, '0, 16'd0, 4'h0, 0, 0, 0);
		send_op(OP_QUERY, 32'hFFFF_FFFF, '0, 32'h0, '0, 16'hFFFF, 4'h0, 0, 0, 0);

		// Fill the table to the brim so the full case shows, then one more add.
		for (int i = 0; i < TableSlots + 1; i++)
			send_op(OP_ADD, 32'h100 + i, '1, $urandom(), '1, 16'(i), 4'($urandom()),
				0, 0, 0);
		send_op(OP_CLEAR, 32'h0, '0, 32'h0, '0, 16'd0, 4'h0, 0, 0, 0);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_DEFAULT_ALGO, 32'hF);
					write_reg(CFG_MIN_ACKS, 32'h0);
				end
				1: begin
					write_reg(CFG_DEFAULT_ALGO, 32'h0);
					write_reg(CFG_MIN_ACKS, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(CFG_DEFAULT_ALGO, 32'(4'h5));
					write_reg(CFG_MIN_ACKS, 32'd50);
				end
				default: begin
					write_reg(CFG_DEFAULT_ALGO, $urandom());
					write_reg(CFG_MIN_ACKS, $urandom_range(0, 200));
				end
			endcase
			// The middle phase leans on adds so the table runs full.
			for (int n = 0; n < RandomOps / 5; n++)
				random_op(phase == 2 ? 55 : 25);
		end
		start <= 1'b0;

		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
